// ===== hw/rtl/aarm_pkg.sv =====
// Package for the axis-angle rotation block: payload types, CORDIC constants,
// arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int ATAN_ENTRIES       = 31;

    // CORDIC datapath: angle and vector in units of 2^-30, 34 bits signed
    localparam int CW = 34;

    localparam logic signed [CW-1:0] INV_GAIN    = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_out;

    // Vector plus residual angle handed along the cell row
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
        logic signed [15:0]   ax;
        logic signed [15:0]   ay;
        logic signed [15:0]   az;
    } t_cell;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd7;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aarm_cell.sv =====
// One CORDIC rotation cell: a micro-rotation by atan(2^-IDX), registered.
// Depends on aarm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aarm_cell import aarm_pkg::*; #(
    parameter int IDX = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_cell i_d,
    output t_cell      o_q
);
    t_cell r_q, n_q;

    always_comb begin
        logic signed [CW-1:0] dx, dy, a;
        dx  = i_d.y >>> IDX;
        dy  = i_d.x >>> IDX;
        a   = atan_q30(IDX);
        n_q = i_d;
        if (!i_d.z[CW-1]) begin
            n_q.x = i_d.x - dx;
            n_q.y = i_d.y + dy;
            n_q.z = i_d.z - a;
        end else begin
            n_q.x = i_d.x + dx;
            n_q.y = i_d.y - dy;
            n_q.z = i_d.z + a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

// ===== hw/rtl/aarm_matrix.sv =====
// Rodrigues matrix assembly: rounds sine and cosine, forms the nine entries
// over three registered steps. Depends on aarm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aarm_matrix import aarm_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_cell i_d,
    output t_out       o_q
);
    localparam int F  = COEF_FRAC_BITS;
    localparam int SH = 30 - F;
    localparam int KW = F + 4;       // width of c, s and t
    localparam int PW = 33;          // axis product
    localparam int AW = PW + KW + 2; // accumulator
    localparam int RS = 14 + F;

    // step 1: rounded c, s, t and axis products
    logic signed [KW-1:0] r_c, r_s, r_t;
    logic signed [PW-1:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    logic signed [15:0]   r_ax, r_ay, r_az;
    // step 2: accumulators
    logic signed [AW-1:0] r_acc [9];
    // step 3: output
    t_out r_out;

    logic signed [CW:0] n_xr, n_yr;
    logic signed [KW-1:0] n_c, n_s;

    always_comb begin
        logic signed [CW:0] xv, yv;
        xv = i_d.flip ? -{i_d.x[CW-1], i_d.x} : {i_d.x[CW-1], i_d.x};
        yv = i_d.flip ? -{i_d.y[CW-1], i_d.y} : {i_d.y[CW-1], i_d.y};
        n_xr = (xv + ((CW+1)'(1) <<< (SH-1))) >>> SH;
        n_yr = (yv + ((CW+1)'(1) <<< (SH-1))) >>> SH;
        n_c  = n_xr[KW-1:0];
        n_s  = n_yr[KW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c   <= n_c;
            r_s   <= n_s;
            r_t   <= (KW)'(1 <<< F) - n_c;
            r_pxx <= PW'(i_d.ax * i_d.ax);
            r_pyy <= PW'(i_d.ay * i_d.ay);
            r_pzz <= PW'(i_d.az * i_d.az);
            r_pxy <= PW'(i_d.ax * i_d.ay);
            r_pxz <= PW'(i_d.ax * i_d.az);
            r_pyz <= PW'(i_d.ay * i_d.az);
            r_ax  <= i_d.ax;
            r_ay  <= i_d.ay;
            r_az  <= i_d.az;
        end
    end

    logic signed [AW-1:0] n_acc [9];
    always_comb begin
        logic signed [AW-1:0] cc, xs, ys, zs, txx, tyy, tzz, txy, txz, tyz;
        cc  = AW'(r_c) <<< 28;
        xs  = AW'(AW'(r_ax) * AW'(r_s)) <<< 14;
        ys  = AW'(AW'(r_ay) * AW'(r_s)) <<< 14;
        zs  = AW'(AW'(r_az) * AW'(r_s)) <<< 14;
        txx = AW'(r_pxx) * AW'(r_t);
        tyy = AW'(r_pyy) * AW'(r_t);
        tzz = AW'(r_pzz) * AW'(r_t);
        txy = AW'(r_pxy) * AW'(r_t);
        txz = AW'(r_pxz) * AW'(r_t);
        tyz = AW'(r_pyz) * AW'(r_t);
        n_acc[0] = txx + cc;
        n_acc[1] = txy - zs;
        n_acc[2] = txz + ys;
        n_acc[3] = txy + zs;
        n_acc[4] = tyy + cc;
        n_acc[5] = tyz - xs;
        n_acc[6] = txz - ys;
        n_acc[7] = tyz + xs;
        n_acc[8] = tzz + cc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_acc[k] <= n_acc[k];
            end
        end
    end

    function automatic logic signed [15:0] finish(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        r = (a + (AW'(1) <<< (RS-1))) >>> RS;
        if (r > AW'(16384)) begin
            return 16'sd16384;
        end else if (r < -AW'(16384)) begin
            return -16'sd16384;
        end
        return r[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.m00 <= finish(r_acc[0]);
            r_out.m01 <= finish(r_acc[1]);
            r_out.m02 <= finish(r_acc[2]);
            r_out.m10 <= finish(r_acc[3]);
            r_out.m11 <= finish(r_acc[4]);
            r_out.m12 <= finish(r_acc[5]);
            r_out.m20 <= finish(r_acc[6]);
            r_out.m21 <= finish(r_acc[7]);
            r_out.m22 <= finish(r_acc[8]);
        end
    end

    assign o_q = r_out;
endmodule
`default_nettype wire

// ===== hw/rtl/axis_angle_rotation_matrix.sv =====
// Axis-angle to 3x3 rotation matrix (Rodrigues form), CORDIC sine/cosine.
// Depends on aarm_pkg, aarm_cell, aarm_matrix.
//
// Usage:
//   Input channel i_valid/o_ready carries t_in (angle Q3.13, axis Q1.14).
//   Output channel o_valid/i_ready carries t_out (nine Q1.14 entries).
//   One request per cycle sustained while the receiver keeps up. The pipeline
//   holds one fold register, one cell per CORDIC micro-rotation, three matrix
//   steps and the output register.
//   The whole pipeline advances as one; when the receiver stalls with a
//   result waiting in the output slot, the pipeline holds and o_ready drops
//   once that slot is full and the pipeline's last stage is occupied.
//   Reset clears all valid bits; payload registers are not reset.
//   No configuration, no state across requests.
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_rotation_matrix import aarm_pkg::*; #(
    parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);
    localparam int DEPTH = CORDIC_STAGES + 4; // fold + cells + 3 matrix steps

    logic [DEPTH-1:0] r_vld;
    logic             en;
    logic             slot_free;

    // advance when the last stage is empty or the output slot can take it
    assign slot_free = !o_valid || i_ready;
    assign en        = !r_vld[DEPTH-1] || slot_free;
    assign o_ready   = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // fold angle into [-pi/2, pi/2]
    t_cell r_fold, n_fold;
    always_comb begin
        logic signed [CW-1:0] z;
        z = CW'(i_data.angle) <<< 17;
        n_fold.x    = INV_GAIN;
        n_fold.y    = '0;
        n_fold.flip = 1'b0;
        n_fold.z    = z;
        if (z > HALF_PI_Q30) begin
            n_fold.z    = z - PI_Q30;
            n_fold.flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            n_fold.z    = z + PI_Q30;
            n_fold.flip = 1'b1;
        end
        n_fold.ax = i_data.axis_x;
        n_fold.ay = i_data.axis_y;
        n_fold.az = i_data.axis_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fold <= n_fold;
        end
    end

    t_cell chain [CORDIC_STAGES+1];
    assign chain[0] = r_fold;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        aarm_cell #(.IDX(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (chain[g]),
            .o_q   (chain[g+1])
        );
    end

    t_out mat;
    aarm_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_matrix (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (chain[CORDIC_STAGES]),
        .o_q   (mat)
    );

    // output slot: hold a waiting result until the receiver takes it
    logic r_ovld;
    t_out r_odata;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (slot_free) begin
            r_ovld <= r_vld[DEPTH-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (slot_free && r_vld[DEPTH-1]) begin
            r_odata <= mat;
        end
    end
    assign o_valid = r_ovld;
    assign o_data  = r_odata;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output changed while stalled");
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("pipeline stalled without backpressure");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_ready) |-> (r_vld[DEPTH-1] && o_valid))
        else $error("stall without full output");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for axis_angle_rotation_matrix: random and directed angle/axis requests,
// CORDIC plus Rodrigues predictor, in-order field compare. Depends on aarm_pkg.
`timescale 1ns / 1ps
module tb_top import aarm_pkg::*; ();

    localparam int STAGES    = 16;
    localparam int FRAC      = 14;
    localparam int LATENCY   = STAGES + 5;
    localparam longint LIMIT = 400000;
    localparam int HOLD_LEN  = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    axis_angle_rotation_matrix uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in    pending_reqs[$];
    t_out   expected_mats[$];
    int     send_idle_pct = 7;
    int     recv_idle_pct = 72;
    bit     hold_off = 1'b0;
    int     hold_cycles = 0;
    longint cycles = 0;
    int     errors = 0;
    int     matched = 0;
    int     n_sent = 0;

    // Arctangent of 2^-i in units of 2^-30.
    function automatic longint atan_step(input int i);
        longint tbl[31] = '{843314857, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127, 63, 31, 15, 7, 3, 1, 0};
        return (i < 31) ? tbl[i] : 0;
    endfunction

    // Flooring round: add half LSB then arithmetic shift.
    function automatic longint round_shift(input longint v, input int sh);
        if (sh == 0)
            return v;
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] sat_entry(input longint acc);
        longint r;
        r = round_shift(acc, 14 + FRAC);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic t_out predict_mat(input t_in req);
        longint z, x, y, dx, dy, c, s, t, ax, ay, az;
        bit flip;
        t_out m;
        z = longint'(req.angle) * 131072;
        ax = req.axis_x;
        ay = req.axis_y;
        az = req.axis_z;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_shift(x, 30 - FRAC);
        s = round_shift(y, 30 - FRAC);
        t = (longint'(1) << FRAC) - c;
        m.m00 = sat_entry(ax * ax * t + c * 268435456);
        m.m01 = sat_entry(ax * ay * t - az * s * 16384);
        m.m02 = sat_entry(ax * az * t + ay * s * 16384);
        m.m10 = sat_entry(ay * ax * t + az * s * 16384);
        m.m11 = sat_entry(ay * ay * t + c * 268435456);
        m.m12 = sat_entry(ay * az * t - ax * s * 16384);
        m.m20 = sat_entry(ax * az * t - ay * s * 16384);
        m.m21 = sat_entry(ay * az * t + ax * s * 16384);
        m.m22 = sat_entry(az * az * t + c * 268435456);
        return m;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'sd0;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic t_in make_req(input int a, input int x, input int y, input int z);
        t_in r;
        r.angle = 16'(a); r.axis_x = 16'(x); r.axis_y = 16'(y); r.axis_z = 16'(z);
        return r;
    endfunction

    // Driver: hold the request until accepted, then advance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (i_valid) begin
                    expected_mats.push_back(predict_mat(i_data));
                    n_sent++;
                end
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_data <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold: count the stretch, then release.
    always @(posedge i_clk) begin
        if (hold_off) begin
            if (hold_cycles >= HOLD_LEN - 1) begin
                hold_cycles <= 0;
                hold_off <= 1'b0;
            end else begin
                hold_cycles <= hold_cycles + 1;
            end
        end
    end

    // Monitor: compare accepted results, pick the next ready value.
    always @(posedge i_clk) begin
        t_out exp_m;
        cycles++;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_mats.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", o_data);
                end else begin
                    exp_m = expected_mats.pop_front();
                    if (exp_m !== o_data) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h actual %h", exp_m, o_data);
                    end else begin
                        matched++;
                    end
                end
            end
            i_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid || expected_mats.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int angles[10] = '{-25736, 25736, 0, 32767, -32768, 12868, -12868, 12869, -12869, 1};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: angle extremes and fold boundaries, axis extremes and non-unit.
        foreach (angles[k])
            pending_reqs.push_back(make_req(angles[k], 16384, 0, 0));
        pending_reqs.push_back(make_req(8000, 0, 16384, 0));
        pending_reqs.push_back(make_req(-8000, 0, 0, 16384));
        pending_reqs.push_back(make_req(20000, -16384, -16384, -16384));
        pending_reqs.push_back(make_req(-20000, 32767, -32768, 32767));
        pending_reqs.push_back(make_req(25736, 9459, 9459, 9459));
        pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768));
        pending_reqs.push_back(make_req(32767, 32767, 32767, 32767));
        pending_reqs.push_back(make_req(-1, 16384, 16384, 0));
        for (int k = 0; k < 550; k++)
            pending_reqs.push_back(make_req(
                ($urandom_range(0, 15) == 0) ? int'($urandom) : $urandom_range(0, 51472) - 25736,
                rand_comp(), rand_comp(), rand_comp()));
        // Long receiver hold while requests keep coming: fills and stalls the pipe.
        hold_off = 1'b1;
        drain();
        send_idle_pct = 72;
        recv_idle_pct = 7;
        for (int k = 0; k < 560; k++)
            pending_reqs.push_back(make_req($urandom_range(0, 51472) - 25736,
                rand_comp(), rand_comp(), rand_comp()));
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 560; k++)
            pending_reqs.push_back(make_req($urandom, $urandom, rand_comp(), rand_comp()));
        drain();
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("covered %0d requests, %0d matrices matched, %0d mismatches",
                 n_sent, matched, errors);
        if (errors == 0 && expected_mats.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end
endmodule
